// ----- design/swpwt_pkg.sv -----
// ----------------------------------------------------------------------------
// Single-wire pulse-width transmitter package
// Shared types, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package swpwt_pkg;

  // Command codes carried in the item's command field.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_SYNC_LOW  = 3'd0;
  localparam logic [2:0] REG_SYNC_HIGH = 3'd1;
  localparam logic [2:0] REG_ONE_LOW   = 3'd2;
  localparam logic [2:0] REG_ONE_HIGH  = 3'd3;
  localparam logic [2:0] REG_ZERO_LOW  = 3'd4;
  localparam logic [2:0] REG_ZERO_HIGH = 3'd5;
  localparam logic [2:0] REG_STOP_LOW  = 3'd6;
  localparam logic [2:0] REG_STOP_HIGH = 3'd7;

  // Register reset values, in ticks.
  localparam logic [7:0] RST_SYNC_LOW  = 8'd40;
  localparam logic [7:0] RST_SYNC_HIGH = 8'd4;
  localparam logic [7:0] RST_ONE_LOW   = 8'd1;
  localparam logic [7:0] RST_ONE_HIGH  = 8'd2;
  localparam logic [7:0] RST_ZERO_LOW  = 8'd2;
  localparam logic [7:0] RST_ZERO_HIGH = 8'd1;
  localparam logic [7:0] RST_STOP_LOW  = 8'd10;
  localparam logic [7:0] RST_STOP_HIGH = 8'd100;

  // Frame phases.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SYNC = 2'd1,
    PH_DATA = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  // Timing configuration as seen by the frame engine.
  typedef struct packed {
    logic [7:0] sync_low_ticks;
    logic [7:0] sync_high_ticks;
    logic [7:0] one_low_ticks;
    logic [7:0] one_high_ticks;
    logic [7:0] zero_low_ticks;
    logic [7:0] zero_high_ticks;
    logic [7:0] stop_low_ticks;
    logic [7:0] stop_high_ticks;
  } cfg_t;

  // One request.
  typedef struct packed {
    logic [1:0] command;
    logic [3:0] byte_index;
    logic [7:0] byte_value;
    logic [4:0] frame_length;
  } item_t;

  // One result.
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } res_t;

endpackage

// ----- design/swpwt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered and returns the
// contents before a write to the same address in the same cycle.
// ----------------------------------------------------------------------------
module swpwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/swpwt_cfg.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the eight tick counts of the frame timing.
// ----------------------------------------------------------------------------
module swpwt_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output swpwt_pkg::cfg_t   cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes; each register keeps the low byte of the write data.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_low_ticks  <= swpwt_pkg::RST_SYNC_LOW;
      cfg.sync_high_ticks <= swpwt_pkg::RST_SYNC_HIGH;
      cfg.one_low_ticks   <= swpwt_pkg::RST_ONE_LOW;
      cfg.one_high_ticks  <= swpwt_pkg::RST_ONE_HIGH;
      cfg.zero_low_ticks  <= swpwt_pkg::RST_ZERO_LOW;
      cfg.zero_high_ticks <= swpwt_pkg::RST_ZERO_HIGH;
      cfg.stop_low_ticks  <= swpwt_pkg::RST_STOP_LOW;
      cfg.stop_high_ticks <= swpwt_pkg::RST_STOP_HIGH;
    end else if (wr_en) begin
      unique case (reg_idx)
        swpwt_pkg::REG_SYNC_LOW:  cfg.sync_low_ticks  <= pwdata[7:0];
        swpwt_pkg::REG_SYNC_HIGH: cfg.sync_high_ticks <= pwdata[7:0];
        swpwt_pkg::REG_ONE_LOW:   cfg.one_low_ticks   <= pwdata[7:0];
        swpwt_pkg::REG_ONE_HIGH:  cfg.one_high_ticks  <= pwdata[7:0];
        swpwt_pkg::REG_ZERO_LOW:  cfg.zero_low_ticks  <= pwdata[7:0];
        swpwt_pkg::REG_ZERO_HIGH: cfg.zero_high_ticks <= pwdata[7:0];
        swpwt_pkg::REG_STOP_LOW:  cfg.stop_low_ticks  <= pwdata[7:0];
        swpwt_pkg::REG_STOP_HIGH: cfg.stop_high_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    prdata = 32'd0;
    unique case (reg_idx)
      swpwt_pkg::REG_SYNC_LOW:  prdata = {24'd0, cfg.sync_low_ticks};
      swpwt_pkg::REG_SYNC_HIGH: prdata = {24'd0, cfg.sync_high_ticks};
      swpwt_pkg::REG_ONE_LOW:   prdata = {24'd0, cfg.one_low_ticks};
      swpwt_pkg::REG_ONE_HIGH:  prdata = {24'd0, cfg.one_high_ticks};
      swpwt_pkg::REG_ZERO_LOW:  prdata = {24'd0, cfg.zero_low_ticks};
      swpwt_pkg::REG_ZERO_HIGH: prdata = {24'd0, cfg.zero_high_ticks};
      swpwt_pkg::REG_STOP_LOW:  prdata = {24'd0, cfg.stop_low_ticks};
      swpwt_pkg::REG_STOP_HIGH: prdata = {24'd0, cfg.stop_high_ticks};
      default: prdata = 32'd0;
    endcase
  end

endmodule

// ----- design/swpwt_engine.sv -----
// ----------------------------------------------------------------------------
// Frame engine
// Holds the frame state and the byte buffer, and works out one request per
// cycle: buffer writes, frame starts and line ticks.
// ----------------------------------------------------------------------------
module swpwt_engine #(
  parameter int MAX_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  swpwt_pkg::item_t  item,
  input  swpwt_pkg::cfg_t   cfg,
  output swpwt_pkg::res_t   res
);

  localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

  // Frame state.
  swpwt_pkg::phase_t phase, phase_next;
  logic [8:0]        tick_count, tick_count_next;
  logic [2:0]        bit_count, bit_count_next;
  logic [4:0]        byte_count, byte_count_next;
  logic [7:0]        shift_byte, shift_byte_next;
  logic [4:0]        length_held, length_held_next;
  logic              line_now, line_now_next;
  logic              done;

  // Buffer access and write forwarding.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          wr_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]    wr_data_q;
  logic [AW-1:0] rd_addr_q;
  logic [7:0]    load_data;

  // Part timing.
  logic [7:0] part_low, part_high;
  logic [8:0] tick_inc, part_sum;
  logic       part_line, part_fin;
  logic [4:0] byte_inc, next_idx;
  logic       frame_end, last_bit;
  logic       is_tick, start_ok;

  swpwt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_buf (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (item.byte_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Request decode.
  assign is_tick  = fire && (item.command == swpwt_pkg::CMD_TICK);
  assign start_ok = fire && (item.command == swpwt_pkg::CMD_START)
                    && (phase == swpwt_pkg::PH_IDLE) && (item.frame_length != 5'd0);
  assign wr_en    = fire && (item.command == swpwt_pkg::CMD_WRITE)
                    && (32'(item.byte_index) < MAX_BYTES);
  assign wr_addr  = AW'(item.byte_index);

  // The buffer is read ahead at the next byte to load: byte 0 outside the
  // data phase, the following byte within it.
  assign byte_inc = byte_count + 5'd1;
  assign next_idx = (phase == swpwt_pkg::PH_DATA) ? byte_inc : 5'd0;
  assign rd_addr  = (32'(next_idx) < MAX_BYTES) ? AW'(next_idx) : '0;

  // A write in the cycle of the read is not yet in the read data.
  assign load_data = (wr_q && (wr_addr_q == rd_addr_q)) ? wr_data_q : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_q <= 1'b0;
    end else begin
      wr_q <= wr_en;
    end
    wr_addr_q <= wr_addr;
    wr_data_q <= item.byte_value;
    rd_addr_q <= rd_addr;
  end

  // Low and high counts of the part in progress.
  always_comb begin
    part_low  = cfg.stop_low_ticks;
    part_high = cfg.stop_high_ticks;
    case (phase)
      swpwt_pkg::PH_SYNC: begin
        part_low  = cfg.sync_low_ticks;
        part_high = cfg.sync_high_ticks;
      end
      swpwt_pkg::PH_DATA: begin
        part_low  = shift_byte[7] ? cfg.one_low_ticks  : cfg.zero_low_ticks;
        part_high = shift_byte[7] ? cfg.one_high_ticks : cfg.zero_high_ticks;
      end
      default: ;
    endcase
  end

  assign tick_inc  = tick_count + 9'd1;
  assign part_sum  = {1'b0, part_low} + {1'b0, part_high};
  assign part_line = (tick_inc > {1'b0, part_low});
  assign part_fin  = (tick_inc >= part_sum);
  assign last_bit  = (bit_count == 3'd7);
  assign frame_end = (byte_inc >= length_held);

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (start_ok) begin
      phase_next = swpwt_pkg::PH_SYNC;
    end else if (is_tick && part_fin) begin
      unique case (phase)
        swpwt_pkg::PH_IDLE: phase_next = swpwt_pkg::PH_IDLE;
        swpwt_pkg::PH_SYNC: phase_next = swpwt_pkg::PH_DATA;
        swpwt_pkg::PH_DATA: begin
          if (last_bit && frame_end) begin
            phase_next = swpwt_pkg::PH_STOP;
          end
        end
        swpwt_pkg::PH_STOP: phase_next = swpwt_pkg::PH_IDLE;
        default: phase_next = phase;
      endcase
    end
  end

  // Counters, shift register and line level.
  always_comb begin
    tick_count_next  = tick_count;
    bit_count_next   = bit_count;
    byte_count_next  = byte_count;
    shift_byte_next  = shift_byte;
    length_held_next = length_held;
    line_now_next    = line_now;
    done             = 1'b0;
    if (start_ok) begin
      length_held_next = (32'(item.frame_length) > MAX_BYTES) ? 5'(MAX_BYTES)
                                                               : item.frame_length;
      tick_count_next  = 9'd0;
      byte_count_next  = 5'd0;
      bit_count_next   = 3'd0;
      line_now_next    = 1'b0;
    end else if (is_tick) begin
      if (phase == swpwt_pkg::PH_IDLE) begin
        line_now_next = 1'b0;
      end else begin
        line_now_next   = part_line;
        tick_count_next = part_fin ? 9'd0 : tick_inc;
        if (part_fin) begin
          case (phase)
            swpwt_pkg::PH_SYNC: begin
              byte_count_next = 5'd0;
              shift_byte_next = load_data;
              bit_count_next  = 3'd0;
            end
            swpwt_pkg::PH_DATA: begin
              if (last_bit) begin
                byte_count_next = byte_inc;
                bit_count_next  = 3'd0;
                shift_byte_next = frame_end ? {shift_byte[6:0], 1'b0} : load_data;
              end else begin
                shift_byte_next = {shift_byte[6:0], 1'b0};
                bit_count_next  = bit_count + 3'd1;
              end
            end
            default: begin
              byte_count_next  = 5'd0;
              bit_count_next   = 3'd0;
              length_held_next = 5'd0;
              done             = 1'b1;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= swpwt_pkg::PH_IDLE;
      tick_count  <= 9'd0;
      bit_count   <= 3'd0;
      byte_count  <= 5'd0;
      shift_byte  <= 8'd0;
      length_held <= 5'd0;
      line_now    <= 1'b0;
    end else begin
      phase       <= phase_next;
      tick_count  <= tick_count_next;
      bit_count   <= bit_count_next;
      byte_count  <= byte_count_next;
      shift_byte  <= shift_byte_next;
      length_held <= length_held_next;
      line_now    <= line_now_next;
    end
  end

  // Result of this request.
  assign res.line_level = line_now_next;
  assign res.busy_res   = (phase_next != swpwt_pkg::PH_IDLE);
  assign res.frame_done = done;

endmodule

// ----- design/single_wire_pulse_width_transmitter.sv -----
// ----------------------------------------------------------------------------
// Single-wire pulse-width transmitter
// Sends frames of buffered bytes as low/high pulse pairs on one wire, one
// level per tick request.
//
// Channel   Direction  Contents
// s_*       in         tuser: command; tdata: byte_index, byte_value,
//                      frame_length
// m_*       out        tdata: line_level, busy_res; tlast: frame_done
// APB       in/out     eight 8-bit tick counts at byte addresses 0 to 28
//
// One request is taken every cycle while s_tready is high. It waits in the
// input register until the frame engine works on it; the result then goes
// into the result register and is presented there until it is taken. The
// frame engine updates its counters once per request.
// Reset is synchronous and leaves the line idle low with no frame running.
// A stalled result holds its register; a request waits in the input register
// and the input side stalls only while both registers are full and the
// result is not being taken.
// ----------------------------------------------------------------------------
module single_wire_pulse_width_transmitter #(
  parameter int MAX_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [3:0] byte_index, [11:4] byte_value,
                                 // [16:12] frame_length, [23:17] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] line_level, [1] busy_res, [7:2] zero
  output logic        m_tlast,   // frame_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  swpwt_pkg::cfg_t  cfg;
  swpwt_pkg::item_t in_item;
  swpwt_pkg::res_t  res, out_res;
  logic             in_valid;
  logic             out_valid;
  logic             proc;

  swpwt_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A request is worked on when the result register is free or emptying.
  assign proc     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || proc;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_item.command      <= s_tuser;
      in_item.byte_index   <= s_tdata[3:0];
      in_item.byte_value   <= s_tdata[11:4];
      in_item.frame_length <= s_tdata[16:12];
    end
  end

  swpwt_engine #(
    .MAX_BYTES (MAX_BYTES)
  ) u_engine (
    .clk  (clk),
    .rst  (rst),
    .fire (proc),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (proc) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_res.busy_res, out_res.line_level};
  assign m_tlast  = out_res.frame_done;

endmodule
